>>> sv/sqe_pkg.sv
// Shared widths, register indexes and arithmetic helpers for the shadow quad extruder.
`timescale 1ns / 1ps
`default_nettype none

package sqe_pkg;

    localparam int COORD_W    = 16;
    localparam int SCALE_W    = 12;
    localparam int POS_W      = COORD_W + 1;
    localparam int DIR_W      = POS_W + 1;
    localparam int CROSS_W    = 2 * DIR_W + 1;
    localparam int OUT_W      = 31;
    localparam int CORNER_W   = 2;
    localparam int QUAD_SLOTS = 8;
    localparam int SLOT_W     = $clog2(QUAD_SLOTS);
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = COORD_W;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1000);

    localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_X = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_Y = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE   = CFG_ADDR_W'(2);

    // Index of the final corner when one or two quads are queued
    localparam logic [SLOT_W-1:0] LAST_ONE_QUAD = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] LAST_TWO_QUAD = SLOT_W'(7);

    // p + s * d, one 13x18 multiply and one add
    function automatic logic signed [OUT_W-1:0] extrude(
        input logic signed [POS_W-1:0]   p,
        input logic signed [DIR_W-1:0]   d,
        input logic        [SCALE_W-1:0] s
    );
        logic signed [OUT_W-1:0] pw;
        logic signed [OUT_W-1:0] dw;
        logic signed [OUT_W-1:0] sw;
        pw = OUT_W'(p);
        dw = OUT_W'(d);
        sw = $signed(OUT_W'(s));
        return pw + sw * dw;
    endfunction

    // dx*ey - dy*ex, two 18x18 multiplies and a subtract
    function automatic logic signed [CROSS_W-1:0] cross2d(
        input logic signed [DIR_W-1:0] dx,
        input logic signed [DIR_W-1:0] dy,
        input logic signed [DIR_W-1:0] ex,
        input logic signed [DIR_W-1:0] ey
    );
        logic signed [CROSS_W-1:0] a;
        logic signed [CROSS_W-1:0] b;
        a = CROSS_W'(dx) * CROSS_W'(ey);
        b = CROSS_W'(dy) * CROSS_W'(ex);
        return a - b;
    endfunction

endpackage

`default_nettype wire

>>> sv/shadow_quad_extruder_unit.sv
// Shadow quad extruder: 2D shadow-volume edge extrusion for one light.
// A word is registered in the input stage, then enters the corner buffer once that is free.
// Throughput: one vertex per cycle when no edge faces away; each back-facing edge
// holds the result buffer for four corners (one per cycle while out_ready is high), so a last
// vertex with two back-facing edges gives eight corners. The corner buffer drain sets this rate.
// Reset: asynchronous, clears light to 0, scale to 1000, stored vertices to 0.
`timescale 1ns / 1ps
`default_nettype none

module shadow_quad_extruder_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic        [sqe_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic        [sqe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [sqe_pkg::COORD_W-1:0]     vertex_x,
    input  logic signed [sqe_pkg::COORD_W-1:0]     vertex_y,
    input  logic signed [sqe_pkg::COORD_W-1:0]     offset_x,
    input  logic signed [sqe_pkg::COORD_W-1:0]     offset_y,
    input  logic                                   first_vertex,
    input  logic                                   last_vertex,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [sqe_pkg::OUT_W-1:0]       out_x,
    output logic signed [sqe_pkg::OUT_W-1:0]       out_y,
    output logic        [sqe_pkg::CORNER_W-1:0]    corner,
    output logic                                   last_result
);

    import sqe_pkg::*;

    // configuration
    logic signed [COORD_W-1:0] light_x_reg;
    logic signed [COORD_W-1:0] light_y_reg;
    logic        [SCALE_W-1:0] scale_reg;

    // polygon state
    logic signed [POS_W-1:0] first_px_reg;
    logic signed [POS_W-1:0] first_py_reg;
    logic signed [POS_W-1:0] prev_px_reg;
    logic signed [POS_W-1:0] prev_py_reg;

    // input stage
    logic                    s1_valid_reg;
    logic                    s1_edge_reg;
    logic                    s1_last_reg;
    logic signed [POS_W-1:0] s1_ax_reg;
    logic signed [POS_W-1:0] s1_ay_reg;
    logic signed [POS_W-1:0] s1_bx_reg;
    logic signed [POS_W-1:0] s1_by_reg;
    logic signed [POS_W-1:0] s1_fx_reg;
    logic signed [POS_W-1:0] s1_fy_reg;

    // corner buffer
    logic                    s2_valid_reg;
    logic [SLOT_W-1:0]       idx_reg;
    logic [SLOT_W-1:0]       last_idx_reg;
    logic signed [OUT_W-1:0] q_x_reg [QUAD_SLOTS];
    logic signed [OUT_W-1:0] q_y_reg [QUAD_SLOTS];
    logic signed [OUT_W-1:0] q_x_next [QUAD_SLOTS];
    logic signed [OUT_W-1:0] q_y_next [QUAD_SLOTS];

    logic                    in_fire;
    logic                    s2_done;
    logic                    s2_free;
    logic                    s1_move;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;

    logic signed [DIR_W-1:0]   dax, day, dbx, dby, dfx, dfy;
    logic signed [DIR_W-1:0]   e1x, e1y, e2x, e2y;
    logic signed [CROSS_W-1:0] cross1, cross2;
    logic signed [OUT_W-1:0]   xa_x, xa_y, xb_x, xb_y, xf_x, xf_y;
    logic                      emit1, emit2;

    assign px = POS_W'(vertex_x) + POS_W'(offset_x);
    assign py = POS_W'(vertex_y) + POS_W'(offset_y);

    assign s2_done  = s2_valid_reg && out_ready && (idx_reg == last_idx_reg);
    assign s2_free  = !s2_valid_reg || s2_done;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= '0;
            light_y_reg <= '0;
            scale_reg   <= SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_LIGHT_X: light_x_reg <= $signed(cfg_data[COORD_W-1:0]);
                REG_LIGHT_Y: light_y_reg <= $signed(cfg_data[COORD_W-1:0]);
                REG_SCALE:   scale_reg   <= cfg_data[SCALE_W-1:0];
                default:     ;
            endcase
        end
    end

    // polygon state follows accepted words directly
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_px_reg <= '0;
            first_py_reg <= '0;
            prev_px_reg  <= '0;
            prev_py_reg  <= '0;
        end
        else if (in_fire)
        begin
            if (first_vertex)
            begin
                first_px_reg <= px;
                first_py_reg <= py;
            end
            prev_px_reg <= px;
            prev_py_reg <= py;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_edge_reg <= !first_vertex;
            s1_last_reg <= last_vertex;
            s1_ax_reg   <= prev_px_reg;
            s1_ay_reg   <= prev_py_reg;
            s1_bx_reg   <= px;
            s1_by_reg   <= py;
            s1_fx_reg   <= first_vertex ? px : first_px_reg;
            s1_fy_reg   <= first_vertex ? py : first_py_reg;
        end
    end

    // edge A->B and closing edge B->F
    always_comb
    begin
        dax = DIR_W'(s1_ax_reg) - DIR_W'(light_x_reg);
        day = DIR_W'(s1_ay_reg) - DIR_W'(light_y_reg);
        dbx = DIR_W'(s1_bx_reg) - DIR_W'(light_x_reg);
        dby = DIR_W'(s1_by_reg) - DIR_W'(light_y_reg);
        dfx = DIR_W'(s1_fx_reg) - DIR_W'(light_x_reg);
        dfy = DIR_W'(s1_fy_reg) - DIR_W'(light_y_reg);
        e1x = DIR_W'(s1_bx_reg) - DIR_W'(s1_ax_reg);
        e1y = DIR_W'(s1_by_reg) - DIR_W'(s1_ay_reg);
        e2x = DIR_W'(s1_fx_reg) - DIR_W'(s1_bx_reg);
        e2y = DIR_W'(s1_fy_reg) - DIR_W'(s1_by_reg);

        cross1 = cross2d(dbx, dby, e1x, e1y);
        cross2 = cross2d(dfx, dfy, e2x, e2y);
        emit1  = s1_edge_reg && (cross1 < 0);
        emit2  = s1_last_reg && (cross2 < 0);

        xa_x = extrude(s1_ax_reg, dax, scale_reg);
        xa_y = extrude(s1_ay_reg, day, scale_reg);
        xb_x = extrude(s1_bx_reg, dbx, scale_reg);
        xb_y = extrude(s1_by_reg, dby, scale_reg);
        xf_x = extrude(s1_fx_reg, dfx, scale_reg);
        xf_y = extrude(s1_fy_reg, dfy, scale_reg);

        // slots 4..7 always hold the closing quad; slots 0..3 the first quad to go out
        q_x_next[4] = OUT_W'(s1_bx_reg);
        q_y_next[4] = OUT_W'(s1_by_reg);
        q_x_next[5] = xb_x;
        q_y_next[5] = xb_y;
        q_x_next[6] = xf_x;
        q_y_next[6] = xf_y;
        q_x_next[7] = OUT_W'(s1_fx_reg);
        q_y_next[7] = OUT_W'(s1_fy_reg);
        if (emit1)
        begin
            q_x_next[0] = OUT_W'(s1_ax_reg);
            q_y_next[0] = OUT_W'(s1_ay_reg);
            q_x_next[1] = xa_x;
            q_y_next[1] = xa_y;
            q_x_next[2] = xb_x;
            q_y_next[2] = xb_y;
            q_x_next[3] = OUT_W'(s1_bx_reg);
            q_y_next[3] = OUT_W'(s1_by_reg);
        end
        else
        begin
            q_x_next[0] = q_x_next[4];
            q_y_next[0] = q_y_next[4];
            q_x_next[1] = q_x_next[5];
            q_y_next[1] = q_y_next[5];
            q_x_next[2] = q_x_next[6];
            q_y_next[2] = q_y_next[6];
            q_x_next[3] = q_x_next[7];
            q_y_next[3] = q_y_next[7];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            idx_reg      <= '0;
            last_idx_reg <= LAST_ONE_QUAD;
        end
        else if (s1_move)
        begin
            s2_valid_reg <= emit1 || emit2;
            idx_reg      <= '0;
            last_idx_reg <= (emit1 && emit2) ? LAST_TWO_QUAD : LAST_ONE_QUAD;
        end
        else if (s2_valid_reg && out_ready)
        begin
            if (s2_done)
            begin
                s2_valid_reg <= 1'b0;
                idx_reg      <= '0;
            end
            else
                idx_reg <= idx_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            for (int i = 0; i < QUAD_SLOTS; i++)
            begin
                q_x_reg[i] <= q_x_next[i];
                q_y_reg[i] <= q_y_next[i];
            end
        end
    end

    assign out_valid   = s2_valid_reg;
    assign out_x       = q_x_reg[idx_reg];
    assign out_y       = q_y_reg[idx_reg];
    assign corner      = idx_reg[CORNER_W-1:0];
    assign last_result = (idx_reg == last_idx_reg);

`ifndef NO_ASSERTIONS
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (idx_reg <= last_idx_reg))
        else $error("corner index past end of buffer");

    a_last_len: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (last_idx_reg == LAST_ONE_QUAD || last_idx_reg == LAST_TWO_QUAD))
        else $error("buffer length not a whole number of quads");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_result) |=> (idx_reg == '0))
        else $error("corner index not restarted after final corner");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg))
        else $error("input stalled with free stage");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_ready) |=> (idx_reg == $past(idx_reg)))
        else $error("corner index moved without a taken word");
`endif

endmodule

`default_nettype wire
